/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* rtl/bssc_pkg.sv */
// Types, codes and tables of the six-step commutation controller.
`timescale 1ns / 1ps
package bssc_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_MAIN    = 2'd0;
    localparam logic [1:0] CMD_REQUEST = 2'd1;
    localparam logic [1:0] CMD_ZC      = 2'd2;
    localparam logic [1:0] CMD_DUTY    = 2'd3;

    // External mode codes
    localparam logic [2:0] MODE_CODE_INVALID = 3'd0;
    localparam logic [2:0] MODE_CODE_INIT    = 3'd1;
    localparam logic [2:0] MODE_CODE_START   = 3'd2;
    localparam logic [2:0] MODE_CODE_COLD    = 3'd3;
    localparam logic [2:0] MODE_CODE_WORK    = 3'd4;
    localparam logic [2:0] MODE_CODE_STALL   = 3'd5;
    localparam logic [2:0] MODE_CODE_STOP    = 3'd6;

    // Zero-cross phase codes
    localparam logic [1:0] PHASE_A = 2'd0;
    localparam logic [1:0] PHASE_B = 2'd1;
    localparam logic [1:0] PHASE_C = 2'd2;

    // Gate drive codes
    localparam logic [1:0] DRV_FLOAT = 2'd0;
    localparam logic [1:0] DRV_LOW   = 2'd1;
    localparam logic [1:0] DRV_HIGH  = 2'd2;

    localparam logic [2:0] STEP_LAST = 3'd5;

    // Configuration register indexes
    localparam logic CFG_IDX_INTERVAL   = 1'b0;
    localparam logic CFG_IDX_COLD_STEPS = 1'b1;

    localparam logic [15:0] INTERVAL_RESET   = 16'd50;
    localparam logic [7:0]  COLD_STEPS_RESET = 8'd18;

    typedef enum logic [6:0] {
        MODE_INVALID = 7'b0000001,
        MODE_INIT    = 7'b0000010,
        MODE_START   = 7'b0000100,
        MODE_COLD    = 7'b0001000,
        MODE_WORK    = 7'b0010000,
        MODE_STALL   = 7'b0100000,
        MODE_STOP    = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now;
        logic [2:0]  request;
        logic [1:0]  zc_phase;
        logic        zc_level;
        logic [7:0]  duty_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0] phase_a_drive;
        logic [1:0] phase_b_drive;
        logic [1:0] phase_c_drive;
        logic [7:0] duty_out;
        logic [2:0] mode;
        logic [2:0] pending_mode;
        logic [2:0] step_out;
        logic       zc_armed;
    } t_out_item;

    typedef struct packed {
        logic [15:0] commute_interval;
        logic [7:0]  cold_start_steps;
    } t_cfg;

    // Drive pattern: C in [5:4], B in [3:2], A in [1:0]
    typedef struct packed {
        t_mode       cur_mode;
        t_mode       next_mode;
        logic [2:0]  step_idx;
        logic [2:0]  applied_step;
        logic [31:0] next_commute_time;
        logic [7:0]  cold_count;
        logic        armed;
        logic [7:0]  duty;
        logic [5:0]  drive;
    } t_state;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            MODE_INIT:  c = MODE_CODE_INIT;
            MODE_START: c = MODE_CODE_START;
            MODE_COLD:  c = MODE_CODE_COLD;
            MODE_WORK:  c = MODE_CODE_WORK;
            MODE_STALL: c = MODE_CODE_STALL;
            MODE_STOP:  c = MODE_CODE_STOP;
            default:    c = MODE_CODE_INVALID;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] step_drive(input logic [2:0] s);
        logic [5:0] d;
        case (s)
            3'd0:    d = {DRV_LOW,   DRV_FLOAT, DRV_HIGH};
            3'd1:    d = {DRV_FLOAT, DRV_LOW,   DRV_HIGH};
            3'd2:    d = {DRV_HIGH,  DRV_LOW,   DRV_FLOAT};
            3'd3:    d = {DRV_HIGH,  DRV_FLOAT, DRV_LOW};
            3'd4:    d = {DRV_FLOAT, DRV_HIGH,  DRV_LOW};
            3'd5:    d = {DRV_LOW,   DRV_HIGH,  DRV_FLOAT};
            default: d = {DRV_FLOAT, DRV_FLOAT, DRV_FLOAT};
        endcase
        return d;
    endfunction

endpackage

/* rtl/bssc_cfg.sv */
// Configuration registers: commutation interval and cold-start step count.
`timescale 1ns / 1ps
module bssc_cfg
    import bssc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.commute_interval <= INTERVAL_RESET;
            r_cfg.cold_start_steps <= COLD_STEPS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_INTERVAL:   r_cfg.commute_interval <= i_cfg_data;
                CFG_IDX_COLD_STEPS: r_cfg.cold_start_steps <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/bssc_ctrl.sv */
// Next-state logic: mode requests, main pass, zero-cross edges and duty writes.
`timescale 1ns / 1ps
module bssc_ctrl
    import bssc_pkg::*;
(
    input  t_state   i_state,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_state   o_state
);

    function automatic t_mode take_request(input t_mode cur, input t_mode nxt,
                                           input logic [2:0] req);
        t_mode res;
        res = nxt;
        unique case (req)
            MODE_CODE_INIT:  if (cur == MODE_STOP || cur == MODE_INVALID) res = MODE_INIT;
            MODE_CODE_START: if (cur == MODE_STOP) res = MODE_START;
            MODE_CODE_COLD:  if (cur == MODE_START) res = MODE_COLD;
            MODE_CODE_WORK:  if (cur == MODE_COLD) res = MODE_WORK;
            MODE_CODE_STALL: if (cur == MODE_WORK) res = MODE_STALL;
            MODE_CODE_STOP:  if (cur != MODE_INVALID) res = MODE_STOP;
            default: ;
        endcase
        return res;
    endfunction

    t_mode       new_mode;
    logic        entry;
    logic [31:0] due_sum;
    logic [31:0] due_time;
    logic [7:0]  count_cur;
    logic [2:0]  step_next;

    always_comb begin
        new_mode  = i_state.next_mode;
        entry     = (i_state.cur_mode != new_mode);
        due_sum   = i_item.now + {16'd0, i_cfg.commute_interval};
        due_time  = (new_mode == MODE_COLD && i_state.cur_mode != MODE_COLD)
                    ? due_sum : i_state.next_commute_time;
        count_cur = (i_state.cur_mode != MODE_COLD) ? 8'd0 : i_state.cold_count;
        step_next = (i_state.step_idx >= STEP_LAST) ? 3'd0 : i_state.step_idx + 3'd1;
    end

    always_comb begin
        o_state = i_state;
        case (i_item.cmd)
            CMD_MAIN: begin
                o_state.cur_mode = new_mode;
                unique case (new_mode)
                    MODE_INIT: begin
                        o_state.duty      = 8'd0;
                        o_state.drive     = 6'd0;
                        o_state.next_mode = MODE_STOP;
                    end
                    MODE_START: o_state.next_mode = MODE_COLD;
                    MODE_COLD: begin
                        o_state.next_commute_time = due_time;
                        o_state.cold_count        = count_cur;
                        if (i_item.now >= due_time) begin
                            o_state.next_commute_time = due_sum;
                            o_state.drive             = step_drive(i_state.step_idx);
                            o_state.step_idx          = step_next;
                            o_state.cold_count        = count_cur + 8'd1;
                            // last open-loop step: hand over to work
                            if (count_cur == i_cfg.cold_start_steps) begin
                                o_state.applied_step = step_next;
                                o_state.next_mode    = MODE_WORK;
                            end
                        end
                    end
                    MODE_WORK: begin
                        o_state.armed = 1'b1;
                        if (i_state.applied_step != i_state.step_idx) begin
                            o_state.drive        = step_drive(i_state.step_idx);
                            o_state.applied_step = i_state.step_idx;
                        end
                    end
                    MODE_STOP: begin
                        if (entry) begin
                            o_state.duty  = 8'd0;
                            o_state.armed = 1'b0;
                            o_state.drive = 6'd0;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_REQUEST: begin
                o_state.next_mode = take_request(i_state.cur_mode, i_state.next_mode,
                                                 i_item.request);
            end
            CMD_ZC: begin
                if (i_state.armed) begin
                    case (i_item.zc_phase)
                        PHASE_A: o_state.step_idx = i_item.zc_level ? 3'd0 : 3'd3;
                        PHASE_B: o_state.step_idx = i_item.zc_level ? 3'd4 : 3'd1;
                        PHASE_C: o_state.step_idx = i_item.zc_level ? 3'd2 : 3'd5;
                        default: ;
                    endcase
                end
            end
            default: o_state.duty = i_item.duty_in;
        endcase
    end

endmodule

/* rtl/bldc_six_step_commutation_control.sv */
// Top level of the six-step sensorless BLDC commutation controller.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+---------------------------
//  input     | i_in_valid / o_in_ready        | i_in_item  (t_in_item)
//  output    | o_out_valid / i_out_ready      | o_out_item (t_out_item)
//  config    | i_cfg_we                       | i_cfg_idx, i_cfg_data
//
// One item per cycle unless the output side stalls; its result is registered at the edge that accepts it.
// The controller state and the result register are written at the same edge
// an item is accepted, from one pass of next-state logic.
// Reset (synchronous, active low) clears the state, config and output valid.
// A held result blocks input only while the output side stalls.
`timescale 1ns / 1ps
module bldc_six_step_commutation_control
    import bssc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

`include "assert_macros.svh"

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      in_fire;
    logic      armed_legal;
    logic      drive_legal;

    bssc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bssc_ctrl u_ctrl (
        .i_state (r_state),
        .i_item  (i_in_item),
        .i_cfg   (cfg),
        .o_state (n_state)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur_mode          <= MODE_INVALID;
            r_state.next_mode         <= MODE_INVALID;
            r_state.step_idx          <= 3'd0;
            r_state.applied_step      <= 3'd0;
            r_state.next_commute_time <= 32'd0;
            r_state.cold_count        <= 8'd0;
            r_state.armed             <= 1'b0;
            r_state.duty              <= 8'd0;
            r_state.drive             <= 6'd0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_item.phase_a_drive <= n_state.drive[1:0];
            r_out_item.phase_b_drive <= n_state.drive[3:2];
            r_out_item.phase_c_drive <= n_state.drive[5:4];
            r_out_item.duty_out      <= n_state.duty;
            r_out_item.mode          <= mode_code(n_state.cur_mode);
            r_out_item.pending_mode  <= mode_code(n_state.next_mode);
            r_out_item.step_out      <= n_state.step_idx;
            r_out_item.zc_armed      <= n_state.armed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign armed_legal = !r_state.armed || r_state.cur_mode == MODE_WORK
                         || r_state.cur_mode == MODE_STALL;
    assign drive_legal = r_state.drive[1:0] != 2'd3 && r_state.drive[3:2] != 2'd3
                         && r_state.drive[5:4] != 2'd3;

    `ASSERT_NEXT(a_result_follows_item, in_fire, o_out_valid, "accepted item left no result")
    `ASSERT_ALWAYS(a_armed_mode, armed_legal, "zero-cross armed outside work or stall")
    `ASSERT_ALWAYS(a_step_range, r_state.step_idx <= STEP_LAST, "step index out of range")
    `ASSERT_ALWAYS(a_drive_codes, drive_legal, "illegal gate drive code")

endmodule

/* verif/bldc_six_step_commutation_control_tb.sv */
// Self-checking testbench for the six-step commutation controller: random sessions, scoreboard.
`timescale 1ns / 1ps
module bldc_six_step_commutation_control_tb;
    import bssc_pkg::*;

    localparam logic [2:0] REQ_UNUSED      = 3'd7;
    localparam int         PHASE_ITEMS     = 480;
    localparam int         OPEN_LOOP_ITEMS = 300;
    localparam int         HOLD_CYCLES     = 64;

    class commutation_scoreboard;
        logic [15:0] interval;
        logic [7:0]  cold_steps;
        logic [2:0]  cur_mode;
        logic [2:0]  pend_mode;
        logic [2:0]  last_mode;
        logic [2:0]  step;
        logic [2:0]  applied;
        logic [31:0] commute_at;
        logic [7:0]  cold_cnt;
        logic        armed;
        logic [7:0]  duty;
        logic [1:0]  drv_a;
        logic [1:0]  drv_b;
        logic [1:0]  drv_c;
        t_out_item   expected_q[$];
        int          errors;

        function new();
            interval   = INTERVAL_RESET;
            cold_steps = COLD_STEPS_RESET;
            cur_mode   = MODE_CODE_INVALID;
            pend_mode  = MODE_CODE_INVALID;
            last_mode  = MODE_CODE_INVALID;
            step       = '0;
            applied    = '0;
            commute_at = '0;
            cold_cnt   = '0;
            armed      = 1'b0;
            duty       = '0;
            errors     = 0;
            float_all();
        endfunction

        function void float_all();
            drv_a = DRV_FLOAT;
            drv_b = DRV_FLOAT;
            drv_c = DRV_FLOAT;
        endfunction

        function void drive_step(logic [2:0] s);
            case (s)
                3'd0:    begin drv_a = DRV_HIGH;  drv_b = DRV_FLOAT; drv_c = DRV_LOW;   end
                3'd1:    begin drv_a = DRV_HIGH;  drv_b = DRV_LOW;   drv_c = DRV_FLOAT; end
                3'd2:    begin drv_a = DRV_FLOAT; drv_b = DRV_LOW;   drv_c = DRV_HIGH;  end
                3'd3:    begin drv_a = DRV_LOW;   drv_b = DRV_FLOAT; drv_c = DRV_HIGH;  end
                3'd4:    begin drv_a = DRV_LOW;   drv_b = DRV_HIGH;  drv_c = DRV_FLOAT; end
                3'd5:    begin drv_a = DRV_FLOAT; drv_b = DRV_HIGH;  drv_c = DRV_LOW;   end
                default: float_all();
            endcase
        endfunction

        // Each mode may only be reached from its allowed source modes; stop from any mode but invalid
        function void request_mode(logic [2:0] r);
            case (r)
                MODE_CODE_INIT:
                    if (cur_mode == MODE_CODE_STOP || cur_mode == MODE_CODE_INVALID)
                        pend_mode = MODE_CODE_INIT;
                MODE_CODE_START: if (cur_mode == MODE_CODE_STOP)  pend_mode = MODE_CODE_START;
                MODE_CODE_COLD:  if (cur_mode == MODE_CODE_START) pend_mode = MODE_CODE_COLD;
                MODE_CODE_WORK:  if (cur_mode == MODE_CODE_COLD)  pend_mode = MODE_CODE_WORK;
                MODE_CODE_STALL: if (cur_mode == MODE_CODE_WORK)  pend_mode = MODE_CODE_STALL;
                MODE_CODE_STOP:  if (cur_mode != MODE_CODE_INVALID) pend_mode = MODE_CODE_STOP;
                default: ;
            endcase
        endfunction

        function void main_pass(logic [31:0] now);
            logic [7:0] old_cnt;
            cur_mode = pend_mode;
            case (cur_mode)
                MODE_CODE_INIT: begin
                    duty = '0;
                    float_all();
                    pend_mode = MODE_CODE_STOP;
                end
                MODE_CODE_START: request_mode(MODE_CODE_COLD);
                MODE_CODE_COLD: begin
                    if (last_mode != MODE_CODE_COLD) begin
                        commute_at = now + interval;
                        cold_cnt   = '0;
                    end
                    // open-loop commutation; the sum wraps at 32 bits
                    if (now >= commute_at) begin
                        commute_at = now + interval;
                        drive_step(step);
                        step     = (step >= STEP_LAST) ? 3'd0 : step + 3'd1;
                        old_cnt  = cold_cnt;
                        cold_cnt = cold_cnt + 8'd1;
                        if (old_cnt == cold_steps) begin
                            applied = step;
                            request_mode(MODE_CODE_WORK);
                        end
                    end
                end
                MODE_CODE_WORK: begin
                    armed = 1'b1;
                    if (applied != step) begin
                        drive_step(step);
                        applied = step;
                    end
                end
                MODE_CODE_STOP:
                    if (last_mode != MODE_CODE_STOP) begin
                        duty  = '0;
                        armed = 1'b0;
                        float_all();
                    end
                default: ;
            endcase
            last_mode = cur_mode;
        endfunction

        function void zero_cross(logic [1:0] ph, logic lvl);
            if (armed) begin
                case (ph)
                    PHASE_A: step = lvl ? 3'd0 : 3'd3;
                    PHASE_B: step = lvl ? 3'd4 : 3'd1;
                    PHASE_C: step = lvl ? 3'd2 : 3'd5;
                    default: ;
                endcase
            end
        endfunction

        function void note_input(t_in_item it);
            t_out_item want;
            case (it.cmd)
                CMD_MAIN:    main_pass(it.now);
                CMD_REQUEST: request_mode(it.request);
                CMD_ZC:      zero_cross(it.zc_phase, it.zc_level);
                default:     duty = it.duty_in;
            endcase
            want.phase_a_drive = drv_a;
            want.phase_b_drive = drv_b;
            want.phase_c_drive = drv_c;
            want.duty_out      = duty;
            want.mode          = cur_mode;
            want.pending_mode  = pend_mode;
            want.step_out      = step;
            want.zc_armed      = armed;
            expected_q.push_back(want);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report("result with no item waiting");
                return;
            end
            want = expected_q.pop_front();
            compare_field("phase_a_drive", got.phase_a_drive, want.phase_a_drive);
            compare_field("phase_b_drive", got.phase_b_drive, want.phase_b_drive);
            compare_field("phase_c_drive", got.phase_c_drive, want.phase_c_drive);
            compare_field("duty_out", got.duty_out, want.duty_out);
            compare_field("mode", got.mode, want.mode);
            compare_field("pending_mode", got.pending_mode, want.pending_mode);
            compare_field("step_out", got.step_out, want.step_out);
            compare_field("zc_armed", got.zc_armed, want.zc_armed);
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    commutation_scoreboard sb;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_off_req = 1'b0;
    int items_sent   = 0;

    bldc_six_step_commutation_control dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int held;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Handshake values are stable at the falling edge; the item moves at the next rising one
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_item);
    end

    // Send one item; the argument fills the field that the command uses, the rest is random
    task automatic issue(input logic [1:0] cmd, input logic [31:0] arg);
        t_in_item    it;
        logic [63:0] noise;
        bit          fire;
        noise = {$urandom, $urandom};
        it = noise[$bits(t_in_item)-1:0];
        it.cmd = cmd;
        case (cmd)
            CMD_MAIN:    it.now = arg;
            CMD_REQUEST: it.request = arg[2:0];
            CMD_ZC:      {it.zc_phase, it.zc_level} = arg[2:0];
            default:     it.duty_in = arg[7:0];
        endcase
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(negedge i_clk);
            fire = o_in_ready;
            @(posedge i_clk);
        end while (!fire);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic set_config(input logic [15:0] interval, input logic [7:0] steps);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_INTERVAL;
        i_cfg_data <= interval;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_COLD_STEPS;
        i_cfg_data <= {8'($urandom), steps};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.interval   = interval;
        sb.cold_steps = steps;
    endtask

    // Drop valid in the step of the last acceptance, then wait out the results
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Stop, init, start, cold start into work, some running, optional stall, stop
    task automatic run_session();
        int          n;
        int          work_len;
        logic [31:0] t_now;
        t_now = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(200000) : $urandom;
        issue(CMD_REQUEST, MODE_CODE_STOP);
        issue(CMD_MAIN, t_now);
        issue(CMD_REQUEST, MODE_CODE_INIT);
        issue(CMD_MAIN, t_now);
        issue(CMD_MAIN, t_now);
        if ($urandom_range(1))
            issue(CMD_DUTY, $urandom);
        issue(CMD_REQUEST, MODE_CODE_START);
        issue(CMD_MAIN, t_now);
        issue(CMD_MAIN, t_now);
        n = 0;
        while (sb.pend_mode == MODE_CODE_COLD && n < 700) begin
            case ($urandom_range(39))
                0, 1:       issue(CMD_ZC, $urandom_range(7));
                2, 3:       issue(CMD_DUTY, $urandom);
                4:          issue(2'($urandom_range(3)), $urandom);
                5, 6, 7, 8, 9, 10, 11, 12: begin
                    // land just short of the commutation time
                    t_now = sb.commute_at - 32'd1 - $urandom_range(sb.interval);
                    issue(CMD_MAIN, t_now);
                end
                default: begin
                    t_now = sb.commute_at + $urandom_range(3);
                    issue(CMD_MAIN, t_now);
                end
            endcase
            n++;
        end
        issue(CMD_MAIN, t_now);
        work_len = $urandom_range(5, 40);
        for (n = 0; n < work_len; n++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: issue(CMD_ZC, $urandom_range(7));
                5, 6, 7: begin
                    t_now += $urandom_range(100);
                    issue(CMD_MAIN, t_now);
                end
                8:       issue(CMD_DUTY, $urandom);
                default: issue(2'($urandom_range(3)), $urandom);
            endcase
        end
        if ($urandom_range(1)) begin
            issue(CMD_REQUEST, MODE_CODE_STALL);
            issue(CMD_MAIN, t_now);
            issue(CMD_ZC, $urandom_range(7));
            issue(CMD_MAIN, t_now);
        end
        issue(CMD_REQUEST, MODE_CODE_STOP);
        issue(CMD_MAIN, t_now);
        issue(CMD_MAIN, t_now);
    endtask

    task automatic run_phase(input logic [15:0] interval, input logic [7:0] steps,
                             input int tx_pct, input int rx_pct, input bit hold,
                             input int budget);
        int first;
        drain();
        set_config(interval, steps);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold)
            hold_off_req = 1'b1;
        first = items_sent;
        while (items_sent - first < budget)
            run_session();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_IDX_INTERVAL;
        i_cfg_data = '0;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: longest interval, cold start ends after its first commutation
        set_config(16'hFFFF, 8'd0);
        issue(CMD_ZC, {PHASE_A, 1'b1});           // disarmed, ignored
        issue(CMD_REQUEST, REQ_UNUSED);
        issue(CMD_REQUEST, MODE_CODE_INVALID);
        issue(CMD_REQUEST, MODE_CODE_STOP);       // not from invalid
        issue(CMD_REQUEST, MODE_CODE_INIT);
        issue(CMD_MAIN, 32'h0000_0000);
        issue(CMD_DUTY, 8'hFF);
        issue(CMD_MAIN, 32'hFFFF_FFFF);
        issue(CMD_REQUEST, MODE_CODE_START);
        issue(CMD_MAIN, 32'h0);
        issue(CMD_REQUEST, MODE_CODE_WORK);       // not from start
        issue(CMD_MAIN, 32'hFFFF_FFF0);           // commutation time wraps past zero
        issue(CMD_MAIN, 32'hFFFF_FFF1);
        issue(CMD_ZC, {PHASE_A, 1'b1});
        issue(CMD_MAIN, 32'h5);
        issue(CMD_ZC, {PHASE_A, 1'b0});
        issue(CMD_ZC, {PHASE_B, 1'b1});
        issue(CMD_ZC, {PHASE_B, 1'b0});
        issue(CMD_ZC, {PHASE_C, 1'b1});
        issue(CMD_ZC, {PHASE_C, 1'b0});
        issue(CMD_ZC, {2'd3, 1'b1});              // no such phase
        issue(CMD_MAIN, 32'h6);
        issue(CMD_REQUEST, MODE_CODE_STALL);
        issue(CMD_MAIN, 32'h7);
        issue(CMD_REQUEST, MODE_CODE_STOP);
        issue(CMD_MAIN, 32'h8);

        // one long open-loop session fills this phase
        run_phase(16'd0, 8'd255, 0, 0, 1'b1, OPEN_LOOP_ITEMS);
        run_phase(16'd1, 8'd3, 65, 0, 1'b0, PHASE_ITEMS);
        run_phase(16'($urandom_range(2, 200)), 8'($urandom_range(8)), 0, 65, 1'b0,
                  PHASE_ITEMS);
        run_phase(16'($urandom_range(2, 65535)), 8'($urandom_range(12)), 16, 16, 1'b0,
                  PHASE_ITEMS);
        drain();

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
